### hdl/vcv_pkg.sv
// Shared constants and types for the vertex camera visibility test.
// No dependencies; imported by vertex_camera_visibility_test.
package vcv_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned AddrW = 6;

  localparam int unsigned PosW   = 20;
  localparam int unsigned NormW  = 16;
  localparam int unsigned CoefW  = 16;
  localparam int unsigned PixW   = 12;
  localparam int unsigned DivBits = 12;

  // Register indexes on paddr[5:3].
  typedef enum logic [2:0] {
    REG_ROT_ROW0  = 3'd0,
    REG_ROT_ROW1  = 3'd1,
    REG_ROT_ROW2  = 3'd2,
    REG_CAM_CTR   = 3'd3,
    REG_PROJ_ROW0 = 3'd4,
    REG_PROJ_ROW1 = 3'd5,
    REG_PROJ_ROW2 = 3'd6,
    REG_IMG_SIZE  = 3'd7
  } reg_idx_e;

  typedef logic [47:0] row_t;

endpackage

### hdl/vertex_camera_visibility_test.sv
// Pinhole camera visibility test: 21-stage pipeline plus APB register file.
// Depends on vcv_pkg.
//
// Usage: program the camera (rotation rows, center, projection rows, image size)
// over the APB port at byte address 8*index, 64-bit data, while idle. Then stream
// vertices on the input channel (valid/ready); each vertex yields one result
// (visible, pixel_u, pixel_v) on the output channel.
// Throughput is one vertex per cycle while the output channel is not stalled.
// The pipeline depth is set by the two matrix products (each a multiply stage
// and a sum stage), the range checks and the 12-step restoring divider that
// produces the pixel coordinates, one quotient bit per stage.
// Each stage advances when it is empty or the next stage moves, so bubbles are
// squeezed out and a stalled receiver backs up the pipeline without losing or
// repeating any transfer; input ready drops only when every stage is full.
// Reset clears all stage valid bits and all camera registers to zero; with a
// zero image size every vertex reports not visible.
module vertex_camera_visibility_test (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [vcv_pkg::AddrW-1:0] paddr,
  input  logic [vcv_pkg::DataW-1:0] pwdata,
  output logic [vcv_pkg::DataW-1:0] prdata,
  output logic                      pready,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [19:0]        vertex_x_i,
  input  logic signed [19:0]        vertex_y_i,
  input  logic signed [19:0]        vertex_z_i,
  input  logic signed [15:0]        normal_x_i,
  input  logic signed [15:0]        normal_y_i,
  input  logic signed [15:0]        normal_z_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      visible_o,
  output logic [11:0]               pixel_u_o,
  output logic [11:0]               pixel_v_o
);
  import vcv_pkg::*;

  localparam int unsigned NumStages = 9 + DivBits;

  // ---------------- configuration registers ----------------
  row_t        rot_q  [3];
  row_t        proj_q [3];
  logic [59:0] ctr_q;
  logic [23:0] size_q;
  logic        wr_en;
  reg_idx_e    wr_idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign wr_idx = reg_idx_e'(paddr[5:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        rot_q[i]  <= '0;
        proj_q[i] <= '0;
      end
      ctr_q  <= '0;
      size_q <= '0;
    end else if (wr_en) begin
      case (wr_idx)
        REG_ROT_ROW0:  rot_q[0]  <= pwdata[47:0];
        REG_ROT_ROW1:  rot_q[1]  <= pwdata[47:0];
        REG_ROT_ROW2:  rot_q[2]  <= pwdata[47:0];
        REG_CAM_CTR:   ctr_q     <= pwdata[59:0];
        REG_PROJ_ROW0: proj_q[0] <= pwdata[47:0];
        REG_PROJ_ROW1: proj_q[1] <= pwdata[47:0];
        REG_PROJ_ROW2: proj_q[2] <= pwdata[47:0];
        REG_IMG_SIZE:  size_q    <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[5:3]))
      REG_ROT_ROW0:  prdata = {16'b0, rot_q[0]};
      REG_ROT_ROW1:  prdata = {16'b0, rot_q[1]};
      REG_ROT_ROW2:  prdata = {16'b0, rot_q[2]};
      REG_CAM_CTR:   prdata = {4'b0, ctr_q};
      REG_PROJ_ROW0: prdata = {16'b0, proj_q[0]};
      REG_PROJ_ROW1: prdata = {16'b0, proj_q[1]};
      REG_PROJ_ROW2: prdata = {16'b0, proj_q[2]};
      REG_IMG_SIZE:  prdata = {40'b0, size_q};
      default:       prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  logic [NumStages-1:0] v_q;
  logic [NumStages-1:0] en;

  always_comb begin
    en[NumStages-1] = !v_q[NumStages-1] || out_ready_i;
    for (int k = NumStages-2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NumStages-1];

  // ---------------- stage 0: offset from camera center ----------------
  logic signed [19:0] pos [3];
  logic signed [15:0] nin [3];
  logic signed [20:0] d_q [3];
  logic signed [15:0] n_q [3];

  assign pos[0] = vertex_x_i;
  assign pos[1] = vertex_y_i;
  assign pos[2] = vertex_z_i;
  assign nin[0] = normal_x_i;
  assign nin[1] = normal_y_i;
  assign nin[2] = normal_z_i;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        d_q[i] <= $signed({pos[i][19], pos[i]})
                - $signed({ctr_q[20*i+19], ctr_q[20*i +: 20]});
        n_q[i] <= nin[i];
      end
    end
  end

  // ---------------- stage 1: rotation and facing products ----------------
  logic signed [36:0] rp_q [3][3];
  logic signed [36:0] fp_q [3];

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          // camera axis i uses column i of R, i.e. transposed rotation
          rp_q[i][j] <= 37'($signed(rot_q[j][16*i +: 16])) * 37'(d_q[j]);
        end
        fp_q[i] <= 37'(n_q[i]) * 37'(d_q[i]);
      end
    end
  end

  // ---------------- stage 2: sums, floor to Q.8, depth and facing ----------------
  logic signed [38:0] exact [3];
  logic signed [38:0] face_sum;
  logic signed [24:0] cam_q [3];
  logic               ok2_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      exact[i] = 39'(rp_q[i][0]) + 39'(rp_q[i][1]) + 39'(rp_q[i][2]);
    end
    face_sum = 39'(fp_q[0]) + 39'(fp_q[1]) + 39'(fp_q[2]);
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      for (int i = 0; i < 3; i++) cam_q[i] <= exact[i][38:14];
      ok2_q <= (exact[2] > 0) && (face_sum > 0);
    end
  end

  // ---------------- stage 3: projection products ----------------
  logic signed [40:0] kp_q [3][3];
  logic               ok3_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          kp_q[i][j] <= 41'($signed(proj_q[i][16*j +: 16])) * 41'(cam_q[j]);
        end
      end
      ok3_q <= ok2_q;
    end
  end

  // ---------------- stage 4: projection sums ----------------
  logic signed [42:0] img_q [3];
  logic               ok4_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      for (int i = 0; i < 3; i++) begin
        img_q[i] <= 43'(kp_q[i][0]) + 43'(kp_q[i][1]) + 43'(kp_q[i][2]);
      end
      ok4_q <= ok3_q;
    end
  end

  // ---------------- stage 5: numerators, positive denominator ----------------
  logic signed [43:0] su, sv;
  logic signed [55:0] su_ext, sv_ext, nu, nv;
  logic signed [43:0] bneg;
  logic signed [55:0] numu_q, numv_q;
  logic [42:0]        den5_q;
  logic               ok5_q;

  always_comb begin
    su     = 44'(img_q[0]) + 44'(img_q[2]);
    sv     = 44'(img_q[1]) + 44'(img_q[2]);
    su_ext = 56'(su);
    sv_ext = 56'(sv);
    nu     = su_ext <<< 10;
    nv     = (sv_ext <<< 9) + (sv_ext <<< 6);
    bneg   = -44'(img_q[2]);
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      if (img_q[2][42]) begin
        numu_q <= -nu;
        numv_q <= -nv;
        den5_q <= bneg[42:0];
      end else begin
        numu_q <= nu;
        numv_q <= nv;
        den5_q <= img_q[2][42:0];
      end
      ok5_q <= ok4_q && (img_q[2] != '0);
    end
  end

  // ---------------- stage 6: scaled bounds ----------------
  logic [54:0]        wden_q, hden_q;
  logic signed [55:0] numu6_q, numv6_q;
  logic [42:0]        den6_q;
  logic               ok6_q;

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      wden_q  <= 55'(size_q[11:0]) * 55'(den5_q);
      hden_q  <= 55'(size_q[23:12]) * 55'(den5_q);
      numu6_q <= numu_q;
      numv6_q <= numv_q;
      den6_q  <= den5_q;
      ok6_q   <= ok5_q;
    end
  end

  // ---------------- stage 7: range test, divider load ----------------
  logic [54:0]        drem_u_q [DivBits+1];
  logic [54:0]        drem_v_q [DivBits+1];
  logic [DivBits-1:0] dq_u_q   [DivBits+1];
  logic [DivBits-1:0] dq_v_q   [DivBits+1];
  logic [42:0]        dden_q   [DivBits+1];
  logic               dok_q    [DivBits+1];
  logic               in_u, in_v;

  // 0 <= num < size*den also bounds the quotient to 12 bits
  assign in_u = !numu6_q[55] && (numu6_q[54:0] < wden_q);
  assign in_v = !numv6_q[55] && (numv6_q[54:0] < hden_q);

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      drem_u_q[0] <= numu6_q[54:0];
      drem_v_q[0] <= numv6_q[54:0];
      dq_u_q[0]   <= '0;
      dq_v_q[0]   <= '0;
      dden_q[0]   <= den6_q;
      dok_q[0]    <= ok6_q && in_u && in_v;
    end
  end

  // ---------------- stages 8..19: restoring divider, one bit each ----------------
  for (genvar k = 0; k < DivBits; k++) begin : g_div
    localparam int unsigned Bit = DivBits - 1 - k;
    logic [54:0] sh;
    logic        take_u, take_v;

    assign sh     = 55'(dden_q[k]) << Bit;
    assign take_u = drem_u_q[k] >= sh;
    assign take_v = drem_v_q[k] >= sh;

    always_ff @(posedge clk_i) begin
      if (en[8+k]) begin
        drem_u_q[k+1] <= take_u ? drem_u_q[k] - sh : drem_u_q[k];
        drem_v_q[k+1] <= take_v ? drem_v_q[k] - sh : drem_v_q[k];
        dq_u_q[k+1]   <= dq_u_q[k] | (DivBits'(take_u) << Bit);
        dq_v_q[k+1]   <= dq_v_q[k] | (DivBits'(take_v) << Bit);
        dden_q[k+1]   <= dden_q[k];
        dok_q[k+1]    <= dok_q[k];
      end
    end
  end

  // ---------------- output stage ----------------
  logic              vis_q;
  logic [PixW-1:0]   pu_q, pv_q;

  always_ff @(posedge clk_i) begin
    if (en[NumStages-1]) begin
      vis_q <= dok_q[DivBits];
      pu_q  <= dok_q[DivBits] ? dq_u_q[DivBits] : '0;
      pv_q  <= dok_q[DivBits] ? dq_v_q[DivBits] : '0;
    end
  end

  assign visible_o = vis_q;
  assign pixel_u_o = pu_q;
  assign pixel_v_o = pv_q;

endmodule
